[design/mtdq_pkg.sv]
// ----------------------------------------------------------------------------
// mtdq_pkg
// Shared types and constants of the multi-timer deadline queue.
// ----------------------------------------------------------------------------
package mtdq_pkg;

    localparam int          ReqW     = 3;
    localparam int          IdW      = 4;
    localparam int          TickW    = 32;
    localparam int          CfgW     = 16;
    localparam int          MaxExp   = 16;
    localparam int          ExpCntW  = 5;
    localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;

    localparam logic [ReqW-1:0] ReqTick      = 3'd0;
    localparam logic [ReqW-1:0] ReqCreate    = 3'd1;
    localparam logic [ReqW-1:0] ReqStart     = 3'd2;
    localparam logic [ReqW-1:0] ReqStop      = 3'd3;
    localparam logic [ReqW-1:0] ReqSetPeriod = 3'd4;
    localparam logic [ReqW-1:0] ReqSetMode   = 3'd5;
    localparam logic [ReqW-1:0] ReqQueryRem  = 3'd6;
    localparam logic [ReqW-1:0] ReqQueryFirst = 3'd7;

    typedef struct packed {
        logic [TickW-1:0] remaining;
        logic [TickW-1:0] reload;
        logic             periodic;
        logic             running;
    } t_cell;

endpackage

[design/multi_timer_deadline_queue.sv]
// ----------------------------------------------------------------------------
// multi_timer_deadline_queue
// Bank of one-shot and periodic timers held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one request: tick, create, start,
// stop, set period, set mode, query remaining or query first. Output channel
// (o_valid/i_ready) returns the results: one acknowledge per request, or for
// a tick one expiry per expiring timer (ascending index, up to 16) with
// o_last on the final one, or a single acknowledge if nothing expired.
// Config channel (i_cfg_valid/o_cfg_ready) writes min_timeout; always ready.
// Every request makes one full turn of the ring, each timer passing in turn
// through the shared head unit, between an accept state and a final state;
// a new request is taken only once the previous one is finished. The
// first result of a tick may appear during the turn.
// A stalled receiver holds the output register; the ring stops turning
// until the pending result is taken, so nothing is lost.
// Reset (synchronous, active low) stops all timers, clears all periods and
// modes, and sets min_timeout to 3.
// ----------------------------------------------------------------------------
module multi_timer_deadline_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_period_ticks,
    input  logic        i_periodic,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic        o_event_kind,
    output logic [3:0]  o_which_timer,
    output logic [31:0] o_remaining,
    output logic        o_running_now,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_min_timeout
);

    localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int XW  = ((IW > mtdq_pkg::IdW) ? IW : mtdq_pkg::IdW) + 1;
    localparam logic [IW-1:0] LastIdx = IW'(NUM_TIMERS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state                     r_state;
    logic [IW-1:0]              r_cnt;
    logic [2:0]                 r_req;
    logic [3:0]                 r_id;
    logic [31:0]                r_per;
    logic                       r_mode;
    logic [15:0]                r_min;
    logic                       r_st, n_st;
    logic [31:0]                r_rem, n_rem;
    logic                       r_run, n_run;
    logic                       r_found, n_found;
    logic [IW-1:0]              r_best, n_best;
    logic [mtdq_pkg::ExpCntW-1:0] r_nexp, n_nexp;
    logic                       r_pend_v;
    logic [IW-1:0]              r_pend_idx;
    logic                       r_pend_run;
    logic                       r_o_valid;
    logic                       r_o_status, r_o_kind, r_o_run, r_o_last;
    logic [3:0]                 r_o_which;
    logic [31:0]                r_o_rem;

    mtdq_pkg::t_cell            w_q [NUM_TIMERS];
    mtdq_pkg::t_cell            n_head;
    logic                       w_shift, w_go, w_exp, w_flush, w_final;

    assign w_go    = !r_o_valid || i_ready;
    assign w_shift = (r_state == S_SCAN) && w_go;
    assign w_flush = w_shift && w_exp && r_pend_v;
    assign w_final = (r_state == S_FIN) && w_go;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_ring
            mtdq_pkg::t_cell w_d;
            if (g == NUM_TIMERS - 1) begin : g_tail
                assign w_d = n_head;
            end else begin : g_mid
                assign w_d = w_q[g+1];
            end
            mtdq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_d),
                .o_q     (w_q[g])
            );
        end
    endgenerate

    // Head unit: apply the request to the timer now at the front of the ring.
    always_comb begin
        mtdq_pkg::t_cell h;
        logic [31:0]     launch_v;
        logic [31:0]     dec;
        logic            match;
        h        = w_q[0];
        n_st     = r_st;
        n_rem    = r_rem;
        n_run    = r_run;
        n_found  = r_found;
        n_best   = r_best;
        n_nexp   = r_nexp;
        w_exp    = 1'b0;
        match    = (XW'(r_cnt) == XW'(r_id));
        launch_v = (h.reload < {16'd0, r_min}) ? {16'd0, r_min} : h.reload;
        dec      = (h.running && h.remaining != 32'd0) ? h.remaining - 32'd1
                                                       : h.remaining;
        unique case (r_req)
            mtdq_pkg::ReqTick: begin
                h.remaining = dec;
                if (h.running && dec == 32'd0
                    && r_nexp < mtdq_pkg::ExpCntW'(mtdq_pkg::MaxExp)) begin
                    w_exp  = 1'b1;
                    n_nexp = r_nexp + 1'b1;
                    if (h.periodic) begin
                        h.remaining = launch_v;
                        h.running   = 1'b1;
                    end else begin
                        h.running = 1'b0;
                    end
                end
            end
            mtdq_pkg::ReqQueryFirst: begin
                if (h.running && (!r_found || h.remaining < r_rem)) begin
                    n_found = 1'b1;
                    n_best  = r_cnt;
                    n_rem   = h.remaining;
                end
            end
            mtdq_pkg::ReqCreate: begin
                if (match) begin
                    h.reload    = r_per;
                    h.periodic  = r_mode;
                    h.running   = 1'b0;
                    h.remaining = 32'd0;
                end
            end
            mtdq_pkg::ReqStart: begin
                if (match) begin
                    if (h.running) begin
                        n_st = 1'b1;
                    end else begin
                        h.remaining = launch_v;
                        h.running   = 1'b1;
                    end
                end
            end
            mtdq_pkg::ReqStop: begin
                if (match) h.running = 1'b0;
            end
            mtdq_pkg::ReqSetPeriod: begin
                if (match) begin
                    h.reload = r_per;
                    if (h.running) begin
                        h.remaining = (r_per < {16'd0, r_min}) ? {16'd0, r_min} : r_per;
                    end
                end
            end
            mtdq_pkg::ReqSetMode: begin
                if (match) h.periodic = r_mode;
            end
            mtdq_pkg::ReqQueryRem: begin
                if (match) begin
                    if (h.running) begin
                        n_rem = h.remaining;
                    end else begin
                        n_st  = 1'b1;
                        n_rem = mtdq_pkg::AllOnes;
                    end
                end
            end
            default: ;
        endcase
        if (match && r_req != mtdq_pkg::ReqTick && r_req != mtdq_pkg::ReqQueryFirst) begin
            n_run = h.running;
        end
        n_head = h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'd3;
        end else if (i_cfg_valid) begin
            r_min <= i_min_timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_req     <= mtdq_pkg::ReqTick;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_flush || w_final) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state  <= S_SCAN;
                        r_cnt    <= '0;
                        r_req    <= i_req_type;
                        r_id     <= i_timer_id;
                        r_per    <= i_period_ticks;
                        r_mode   <= i_periodic;
                        // out-of-range id never matches: answer invalid
                        r_st     <= !(XW'(i_timer_id) < XW'(NUM_TIMERS));
                        r_rem    <= (i_req_type == mtdq_pkg::ReqQueryFirst)
                                    ? mtdq_pkg::AllOnes : 32'd0;
                        r_run    <= 1'b0;
                        r_found  <= 1'b0;
                        r_best   <= '0;
                        r_nexp   <= '0;
                        r_pend_v <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_go) begin
                        r_st    <= n_st;
                        r_rem   <= n_rem;
                        r_run   <= n_run;
                        r_found <= n_found;
                        r_best  <= n_best;
                        r_nexp  <= n_nexp;
                        r_cnt   <= r_cnt + 1'b1;
                        if (r_cnt == LastIdx) r_state <= S_FIN;
                        if (w_exp) begin
                            // hold the newest expiry; flush the previous one
                            r_pend_v   <= 1'b1;
                            r_pend_idx <= r_cnt;
                            r_pend_run <= n_head.running;
                            if (r_pend_v) begin
                                r_o_status <= 1'b0;
                                r_o_kind   <= 1'b1;
                                r_o_which  <= 4'(r_pend_idx);
                                r_o_rem    <= 32'd0;
                                r_o_run    <= r_pend_run;
                                r_o_last   <= 1'b0;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (w_go) begin
                        r_state  <= S_IDLE;
                        r_o_last <= 1'b1;
                        if (r_req == mtdq_pkg::ReqTick) begin
                            r_o_status <= 1'b0;
                            r_o_rem    <= 32'd0;
                            r_o_kind   <= r_pend_v;
                            r_o_which  <= r_pend_v ? 4'(r_pend_idx) : 4'd0;
                            r_o_run    <= r_pend_v && r_pend_run;
                        end else if (r_req == mtdq_pkg::ReqQueryFirst) begin
                            r_o_status <= 1'b0;
                            r_o_kind   <= 1'b0;
                            r_o_rem    <= r_rem;
                            r_o_which  <= r_found ? 4'(r_best) : 4'd0;
                            r_o_run    <= r_found;
                        end else begin
                            r_o_status <= r_st;
                            r_o_kind   <= 1'b0;
                            r_o_which  <= r_id;
                            r_o_rem    <= r_rem;
                            r_o_run    <= r_run;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_event_kind  = r_o_kind;
    assign o_which_timer = r_o_which;
    assign o_remaining   = r_o_rem;
    assign o_running_now = r_o_run;
    assign o_last        = r_o_last;

endmodule

[design/mtdq_cell.sv]
// ----------------------------------------------------------------------------
// mtdq_cell
// One timer slot of the rotating ring; takes its neighbor's state on shift.
// ----------------------------------------------------------------------------
module mtdq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  mtdq_pkg::t_cell i_d,
    output mtdq_pkg::t_cell o_q
);

    mtdq_pkg::t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[design/mtdq_checker.sv]
// ----------------------------------------------------------------------------
// mtdq_checker
// Port-level checks of the multi-timer deadline queue, bound to the top.
// ----------------------------------------------------------------------------
module mtdq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_status,
    input logic        o_event_kind,
    input logic [31:0] o_remaining,
    input logic        o_last,
    input logic        o_cfg_ready
);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while previous one in flight");

    a_expiry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind |-> !o_status && o_remaining == 32'd0)
        else $error("expiry with nonzero status or remaining");

    a_ack_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_event_kind |-> o_last)
        else $error("acknowledge not marked last");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_remaining) && $stable(o_last))
        else $error("result dropped or changed under stall");

endmodule

bind multi_timer_deadline_queue mtdq_checker u_mtdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_event_kind (o_event_kind),
    .o_remaining  (o_remaining),
    .o_last       (o_last),
    .o_cfg_ready  (o_cfg_ready)
);

[tb/mtdq_checker.sv]
// ----------------------------------------------------------------------------
// mtdq_tb_checker
// Watches the request, result and config channels, keeps a shadow timer bank
// and compares each result with the oldest predicted one.
// ----------------------------------------------------------------------------
module mtdq_tb_checker #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_period_ticks,
    input  logic        i_periodic,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_status,
    input  logic        i_event_kind,
    input  logic [3:0]  i_which_timer,
    input  logic [31:0] i_remaining,
    input  logic        i_running_now,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_min_timeout,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        status;
        logic        event_kind;
        logic [3:0]  which_timer;
        logic [31:0] remaining;
        logic        running_now;
        logic        last;
    } t_result;

    logic [31:0] sh_rem [NUM_TIMERS];
    logic [31:0] sh_reload [NUM_TIMERS];
    logic        sh_per [NUM_TIMERS];
    logic        sh_run [NUM_TIMERS];
    logic [15:0] sh_min;
    t_result     result_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();

    function automatic t_result mk(logic st, logic kd, logic [3:0] w, logic [31:0] r,
                                   logic rn, logic l);
        t_result x;
        x = '{st, kd, w, r, rn, l};
        return x;
    endfunction

    task automatic load_timer(int t);
        sh_rem[t] = (sh_reload[t] < {16'd0, sh_min}) ? {16'd0, sh_min} : sh_reload[t];
        sh_run[t] = 1'b1;
    endtask

    task automatic predict_request(logic [2:0] req, logic [3:0] id, logic [31:0] per,
                                   logic mode);
        int n;
        int best;
        logic st;
        logic [31:0] rem;
        n = 0;
        best = -1;
        st = 1'b0;
        rem = '0;
        if (req == mtdq_pkg::ReqTick) begin
            for (int i = 0; i < NUM_TIMERS; i++)
                if (sh_run[i] && sh_rem[i] != 0) sh_rem[i]--;
            for (int i = 0; i < NUM_TIMERS && n < mtdq_pkg::MaxExp; i++) begin
                if (sh_run[i] && sh_rem[i] == 0) begin
                    sh_run[i] = 1'b0;
                    if (sh_per[i]) load_timer(i);
                    result_q.push_back(mk(1'b0, 1'b1, 4'(i), '0, sh_run[i], 1'b0));
                    n++;
                end
            end
            if (n == 0) result_q.push_back(mk(1'b0, 1'b0, '0, '0, 1'b0, 1'b1));
            else result_q[$].last = 1'b1;
        end else if (req == mtdq_pkg::ReqQueryFirst) begin
            for (int i = 0; i < NUM_TIMERS; i++)
                if (sh_run[i] && (best < 0 || sh_rem[i] < sh_rem[best])) best = i;
            if (best >= 0)
                result_q.push_back(mk(1'b0, 1'b0, 4'(best), sh_rem[best], 1'b1, 1'b1));
            else
                result_q.push_back(mk(1'b0, 1'b0, '0, mtdq_pkg::AllOnes, 1'b0, 1'b1));
        end else if (int'(id) >= NUM_TIMERS) begin
            result_q.push_back(mk(1'b1, 1'b0, id, '0, 1'b0, 1'b1));
        end else begin
            case (req)
                mtdq_pkg::ReqCreate: begin
                    sh_reload[id] = per;
                    sh_per[id] = mode;
                    sh_run[id] = 1'b0;
                    sh_rem[id] = '0;
                end
                mtdq_pkg::ReqStart: begin
                    if (sh_run[id]) st = 1'b1;
                    else load_timer(id);
                end
                mtdq_pkg::ReqStop: sh_run[id] = 1'b0;
                mtdq_pkg::ReqSetPeriod: begin
                    sh_reload[id] = per;
                    if (sh_run[id]) load_timer(id);
                end
                mtdq_pkg::ReqSetMode: sh_per[id] = mode;
                default: begin
                    if (sh_run[id]) rem = sh_rem[id];
                    else begin
                        st = 1'b1;
                        rem = mtdq_pkg::AllOnes;
                    end
                end
            endcase
            result_q.push_back(mk(st, 1'b0, id, rem, sh_run[id], 1'b1));
        end
    endtask

    task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                sh_rem[i] = '0;
                sh_reload[i] = '0;
                sh_per[i] = 1'b0;
                sh_run[i] = 1'b0;
            end
            sh_min = 16'd3;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) sh_min = i_min_timeout;
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with nothing expected");
                    fails++;
                end else begin
                    e = result_q.pop_front();
                    field_check("status", 32'(e.status), 32'(i_status));
                    field_check("event_kind", 32'(e.event_kind), 32'(i_event_kind));
                    field_check("which_timer", 32'(e.which_timer), 32'(i_which_timer));
                    field_check("remaining", e.remaining, i_remaining);
                    field_check("running_now", 32'(e.running_now), 32'(i_running_now));
                    field_check("last", 32'(e.last), 32'(i_last));
                end
            end
            if (i_valid && i_ready_in)
                predict_request(i_req_type, i_timer_id, i_period_ticks, i_periodic);
        end
    end
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random timer requests with bursty sends, a stalling
// receiver and several min_timeout settings; the checker judges the results.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  req_type;
    logic [3:0]  req_id;
    logic [31:0] req_period;
    logic        req_mode;
    logic        res_valid;
    logic        res_ready;
    logic        res_status;
    logic        res_kind;
    logic [3:0]  res_which;
    logic [31:0] res_remaining;
    logic        res_running;
    logic        res_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_min;
    int          fail_count;
    int          pending;
    int          burst_left;
    int          stall_mode;

    multi_timer_deadline_queue #(.NUM_TIMERS(16)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_req_type(req_type), .i_timer_id(req_id),
        .i_period_ticks(req_period), .i_periodic(req_mode),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_status(res_status), .o_event_kind(res_kind), .o_which_timer(res_which),
        .o_remaining(res_remaining), .o_running_now(res_running), .o_last(res_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_min_timeout(cfg_min)
    );

    mtdq_tb_checker #(.NUM_TIMERS(16)) checker_u (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .i_ready_in(req_ready),
        .i_req_type(req_type), .i_timer_id(req_id),
        .i_period_ticks(req_period), .i_periodic(req_mode),
        .i_out_valid(res_valid), .i_out_ready(res_ready),
        .i_status(res_status), .i_event_kind(res_kind), .i_which_timer(res_which),
        .i_remaining(res_remaining), .i_running_now(res_running), .i_last(res_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_min_timeout(cfg_min),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: switch stall patterns now and then.
    always @(negedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            stall_mode = 0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 3) != 0);
                2: res_ready <= ($urandom_range(0, 1) != 0);
                default: res_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic send_req(logic [2:0] t, logic [3:0] id, logic [31:0] p, logic m);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end else begin
            @(negedge clk);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_type <= t;
        req_id <= id;
        req_period <= p;
        req_mode <= m;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic write_min(logic [15:0] v);
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_min <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [2:0] t;
        for (int k = 0; k < count; k++) begin
            // Ticks dominate so that timers actually expire.
            if ($urandom_range(0, 2) == 0) t = mtdq_pkg::ReqTick;
            else t = 3'($urandom_range(1, 7));
            send_req(t, 4'($urandom_range(0, 15)), rand_period(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = '0;
        req_id = '0;
        req_period = '0;
        req_mode = 1'b0;
        cfg_valid = 1'b0;
        cfg_min = '0;
        burst_left = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: queries on idle bank, create/start/stop, saturation, zero period.
        send_req(mtdq_pkg::ReqQueryFirst, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqQueryRem, 4'd15, '0, 1'b0);
        send_req(mtdq_pkg::ReqTick, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqCreate, 4'd0, 32'd1, 1'b0);
        send_req(mtdq_pkg::ReqStart, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqStart, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqCreate, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_req(mtdq_pkg::ReqStart, 4'd15, '0, 1'b0);
        send_req(mtdq_pkg::ReqQueryRem, 4'd15, '0, 1'b0);
        send_req(mtdq_pkg::ReqQueryFirst, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqSetPeriod, 4'd15, 32'd2, 1'b1);
        send_req(mtdq_pkg::ReqSetMode, 4'd0, '0, 1'b1);
        repeat (4) send_req(mtdq_pkg::ReqTick, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqStop, 4'd15, '0, 1'b0);
        send_req(mtdq_pkg::ReqStop, 4'd7, '0, 1'b0);
        write_min(16'd0);
        for (int i = 0; i < 16; i++) begin
            send_req(mtdq_pkg::ReqCreate, 4'(i), 32'd0, 1'b1);
            send_req(mtdq_pkg::ReqStart, 4'(i), '0, 1'b0);
        end
        repeat (3) send_req(mtdq_pkg::ReqTick, 4'd0, '0, 1'b0);
        send_req(mtdq_pkg::ReqSetPeriod, 4'd3, 32'd5, 1'b0);
        send_req(mtdq_pkg::ReqQueryFirst, 4'd0, '0, 1'b0);

        random_phase(120);
        write_min(16'hFFFF);
        random_phase(55);
        write_min(16'd1);
        random_phase(95);
        write_min(16'($urandom_range(0, 6)));
        random_phase(95);

        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
